// ===== sv/ycc2rgb_pkg.sv =====
// Package for the YCbCr channel merge block: Q16 types, coefficients,
// channel codes and the clamp / matrix functions. No dependencies.
package ycc2rgb_pkg;

   typedef logic signed [26:0] q16_type;

   typedef struct packed {
      logic [7:0] third;
      logic [7:0] second;
      logic [7:0] first;
   } pixel_type;

   typedef struct packed {
      q16_type third;
      q16_type second;
      q16_type first;
   } q16_trip_type;

   localparam logic [7:0] CH_Y  = 8'd1;
   localparam logic [7:0] CH_CB = 8'd2;
   localparam logic [7:0] CH_CR = 8'd3;

   localparam logic [2:0] FULL_MASK  = 3'b111;
   localparam logic [7:0] FLAGS_YCC  = 8'h07;
   localparam logic [7:0] FLAGS_RGB  = 8'hFF;

   localparam q16_type OFFSET_128 = q16_type'(128 * 65536);
   localparam q16_type Q16_MAX    = q16_type'(255 * 65536);
   localparam q16_type CHROMA_MID = q16_type'(128);

   localparam q16_type K_Y_R  = q16_type'(19595);
   localparam q16_type K_Y_G  = q16_type'(38470);
   localparam q16_type K_Y_B  = q16_type'(7471);
   localparam q16_type K_CB_R = q16_type'(-11058);
   localparam q16_type K_CB_G = q16_type'(-21710);
   localparam q16_type K_CB_B = q16_type'(32768);
   localparam q16_type K_CR_R = q16_type'(32768);
   localparam q16_type K_CR_G = q16_type'(-27439);
   localparam q16_type K_CR_B = q16_type'(-5329);

   localparam q16_type K_R_CR = q16_type'(91881);
   localparam q16_type K_G_CB = q16_type'(22554);
   localparam q16_type K_G_CR = q16_type'(46801);
   localparam q16_type K_B_CB = q16_type'(116130);

   function automatic q16_type widen(input logic [7:0] v);
      return q16_type'({19'd0, v});
   endfunction

   function automatic logic [7:0] clamp_q16(input q16_type v);
      logic [7:0] res;
      if (v < 0) begin
         res = 8'd0;
      end else if (v > Q16_MAX) begin
         res = 8'hFF;
      end else begin
         res = v[23:16];
      end
      return res;
   endfunction

   function automatic q16_trip_type ycc_from_rgb(input pixel_type p);
      q16_trip_type s;
      q16_type r;
      q16_type g;
      q16_type b;
      r = widen(p.first);
      g = widen(p.second);
      b = widen(p.third);
      s.first  = K_Y_R * r + K_Y_G * g + K_Y_B * b;
      s.second = K_CB_R * r + K_CB_G * g + K_CB_B * b + OFFSET_128;
      s.third  = K_CR_R * r + K_CR_G * g + K_CR_B * b + OFFSET_128;
      return s;
   endfunction

   function automatic q16_trip_type rgb_from_ycc(input pixel_type p);
      q16_trip_type s;
      q16_type y;
      q16_type cb;
      q16_type cr;
      y  = q16_type'({3'd0, p.first, 16'd0});
      cb = widen(p.second) - CHROMA_MID;
      cr = widen(p.third) - CHROMA_MID;
      s.first  = y + K_R_CR * cr;
      s.second = y - K_G_CB * cb - K_G_CR * cr;
      s.third  = y + K_B_CB * cb;
      return s;
   endfunction

   function automatic pixel_type clamp_trip(input q16_trip_type s);
      pixel_type p;
      p.first  = clamp_q16(s.first);
      p.second = clamp_q16(s.second);
      p.third  = clamp_q16(s.third);
      return p;
   endfunction

endpackage

// ===== sv/ycbcr_channel_merge_to_rgb.sv =====
// YCbCr channel merge with conversion to RGB, four register stages.
// Depends on ycc2rgb_pkg.
//
//  channel  dir  handshake          payload
//  req_     in   tvalid / tready    tdata: first, second, third, flags, sample; tuser: channel
//  rsp_     out  tvalid / tready    tdata: first, second, third, flags
//
// One pixel per cycle unless rsp_tready stalls; a req passes stages 1-4 to rsp_tvalid.
// Stage 1 forms RGB->YCbCr sums, stage 2 clamps and merges the sample,
// stage 3 forms YCbCr->RGB sums, stage 4 clamps into the output register.
// Each stage advances when the next is empty or advancing; a stall holds all data.
// Synchronous active-high reset clears the valid bits only.
module ycbcr_channel_merge_to_rgb (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // pixel_first, pixel_second, pixel_third, pixel_flags, sample
   input  logic [7:0]  req_tuser,   // channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // out_first, out_second, out_third, out_flags
);
   import ycc2rgb_pkg::*;

   logic rdy1, rdy2, rdy3, rdy4;

   // stage 1
   logic         v1_ff;
   logic         full1_ff;
   pixel_type    px1_ff;
   q16_trip_type sum1_ff;
   logic [7:0]   flags1_ff, sample1_ff, chan1_ff;
   pixel_type    px_req;

   // stage 2
   logic         v2_ff, full2_ff;
   pixel_type    px2_ff, px2_in;
   logic [7:0]   flags2_ff, flags2_in;

   // stage 3
   logic         v3_ff, full3_ff;
   pixel_type    px3_ff;
   q16_trip_type sum3_ff;
   logic [7:0]   flags3_ff;

   // output
   logic         v4_ff;
   logic [31:0]  data4_ff;
   pixel_type    px4_in;

   assign rdy4 = !v4_ff || rsp_tready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_tready = rdy1;

   assign px_req = pixel_type'(req_tdata[23:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (rdy1) begin
         v1_ff <= req_tvalid;
      end
      if (rdy1) begin
         px1_ff     <= px_req;
         sum1_ff    <= ycc_from_rgb(px_req);
         full1_ff   <= (req_tdata[26:24] == FULL_MASK);
         flags1_ff  <= req_tdata[31:24];
         sample1_ff <= req_tdata[39:32];
         chan1_ff   <= req_tuser;
      end
   end

   always_comb begin
      px2_in    = full1_ff ? clamp_trip(sum1_ff) : px1_ff;
      flags2_in = full1_ff ? FLAGS_YCC : flags1_ff;
      case (chan1_ff)
         CH_Y: begin
            px2_in.first = sample1_ff;
            flags2_in[0] = 1'b1;
         end
         CH_CB: begin
            px2_in.second = sample1_ff;
            flags2_in[1]  = 1'b1;
         end
         CH_CR: begin
            px2_in.third = sample1_ff;
            flags2_in[2] = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (rdy2) begin
         v2_ff <= v1_ff;
      end
      if (rdy2) begin
         px2_ff    <= px2_in;
         flags2_ff <= flags2_in;
         full2_ff  <= (flags2_in[2:0] == FULL_MASK);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (rdy3) begin
         v3_ff <= v2_ff;
      end
      if (rdy3) begin
         px3_ff    <= px2_ff;
         sum3_ff   <= rgb_from_ycc(px2_ff);
         flags3_ff <= flags2_ff;
         full3_ff  <= full2_ff;
      end
   end

   assign px4_in = full3_ff ? clamp_trip(sum3_ff) : px3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (rdy4) begin
         v4_ff <= v3_ff;
      end
      if (rdy4) begin
         data4_ff <= {(full3_ff ? FLAGS_RGB : flags3_ff), px4_in};
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = data4_ff;

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> v1_ff)
      else $error("accepted transfer did not reach stage 1");

   a_full_flags: assert property (@(posedge clock) disable iff (reset)
      v2_ff && full2_ff |-> flags2_ff[2:0] == FULL_MASK)
      else $error("stage 2 full mark disagrees with flags");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      v2_ff && !rdy3 |=> v2_ff && $stable(px2_ff) && $stable(flags2_ff))
      else $error("stage 2 changed while stalled");

   a_out_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[26:24] != FULL_MASK) || (rsp_tdata[31:24] == FLAGS_RGB))
      else $error("full pixel left unconverted");

endmodule
